// ===== rtl/rcfd_pkg.sv =====
package rcfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 2);
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int STICK_W     = 11;
    localparam int CHAN_W      = 16;
    localparam int SW_W        = 2;

    localparam logic [STICK_W-1:0] OFFSET_RST   = 11'd1024;
    localparam logic [STICK_W-1:0] LIMIT_RST    = 11'd660;
    localparam logic [SW_W-1:0]    FAILSAFE_RST = 2'd2;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_IDLE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REG_OFFSET   = 2'd0,
        REG_LIMIT    = 2'd1,
        REG_FAILSAFE = 2'd2
    } reg_idx_t;

    typedef logic [7:0] frame_t [FRAME_BYTES];

    typedef struct packed {
        logic [STICK_W-1:0] offset;
        logic [STICK_W-1:0] limit;
        logic [SW_W-1:0]    failsafe_sw;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic complete;
    } store_stat_t;

    function automatic logic [CHAN_W-1:0] chan_sub(
        input logic [CHAN_W-1:0]  raw,
        input logic [STICK_W-1:0] offset
    );
        return raw - {{(CHAN_W - STICK_W){1'b0}}, offset};
    endfunction

    // stick channels stay within +/-2047 after the subtract
    function automatic logic over_limit(
        input logic [CHAN_W-1:0]  chan,
        input logic [STICK_W-1:0] limit
    );
        logic [CHAN_W-1:0]  neg;
        logic [STICK_W:0]   mag;
        neg = -chan;
        mag = chan[CHAN_W-1] ? neg[STICK_W:0] : chan[STICK_W:0];
        return mag > {1'b0, limit};
    endfunction

endpackage

// ===== rtl/rcfd_in_if.sv =====
interface rcfd_in_if;
    import rcfd_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

// ===== rtl/rcfd_out_if.sv =====
interface rcfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] chan0;
    logic signed [15:0] chan1;
    logic signed [15:0] chan2;
    logic signed [15:0] chan3;
    logic signed [15:0] chan4;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_word;
    logic               status;

    modport source (
        output valid, output chan0, output chan1, output chan2, output chan3,
        output chan4, output switches, output mouse_x, output mouse_y,
        output mouse_z, output mouse_buttons, output key_word, output status,
        input ready
    );
    modport sink (
        input valid, input chan0, input chan1, input chan2, input chan3,
        input chan4, input switches, input mouse_x, input mouse_y,
        input mouse_z, input mouse_buttons, input key_word, input status,
        output ready
    );
endinterface

// ===== rtl/rcfd_regs.sv =====
module rcfd_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcfd_pkg::DATA_W-1:0]   pwdata,
    output logic [rcfd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rcfd_pkg::cfg_t                cfg
);
    import rcfd_pkg::*;

    logic [STICK_W-1:0] offset_reg;
    logic [STICK_W-1:0] limit_reg;
    logic [SW_W-1:0]    failsafe_reg;
    reg_idx_t           idx;
    logic               wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= OFFSET_RST;
            limit_reg    <= LIMIT_RST;
            failsafe_reg <= FAILSAFE_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_OFFSET:   offset_reg   <= pwdata[STICK_W-1:0];
                REG_LIMIT:    limit_reg    <= pwdata[STICK_W-1:0];
                REG_FAILSAFE: failsafe_reg <= pwdata[SW_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_OFFSET:   prdata = {{(DATA_W - STICK_W){1'b0}}, offset_reg};
            REG_LIMIT:    prdata = {{(DATA_W - STICK_W){1'b0}}, limit_reg};
            REG_FAILSAFE: prdata = {{(DATA_W - SW_W){1'b0}}, failsafe_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg = '{offset: offset_reg, limit: limit_reg, failsafe_sw: failsafe_reg};

endmodule

// ===== rtl/rcfd_store.sv =====
module rcfd_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  rcfd_pkg::opcode_t     opcode,
    input  logic [7:0]            rx_byte,
    output rcfd_pkg::frame_t      frame,
    output rcfd_pkg::store_stat_t stat
);
    import rcfd_pkg::*;

    localparam logic [COUNT_W-1:0] FULL = COUNT_W'(FRAME_BYTES);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    frame_t             store_reg;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (opcode == OP_IDLE)
                count_next = '0;
            else if (count_reg <= FULL)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (accept && opcode == OP_BYTE && count_reg == COUNT_W'(i))
                store_reg[i] <= rx_byte;
        end
    end

    assign frame         = store_reg;
    assign stat.complete = (count_reg == FULL);
    assign stat.load     = accept && opcode == OP_IDLE && count_reg == FULL;

`ifndef SYNTHESIS
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL + 1'b1)
        else $error("byte count past saturation");
    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_IDLE |=> count_reg == '0)
        else $error("idle word did not clear count");
`endif

endmodule

// ===== rtl/rcfd_decode.sv =====
module rcfd_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcfd_pkg::frame_t      frame,
    input  rcfd_pkg::store_stat_t stat,
    input  rcfd_pkg::cfg_t        cfg,
    rcfd_out_if.source            res
);
    import rcfd_pkg::*;

    logic [CHAN_W-1:0]  ch0, ch1, ch2, ch3, ch4;
    logic [SW_W-1:0]    sw_l, sw_r;
    logic               bad;

    logic               valid_reg;
    logic [CHAN_W-1:0]  ch0_reg, ch1_reg, ch2_reg, ch3_reg, ch4_reg;
    logic [3:0]         sw_reg;
    logic [15:0]        mx_reg, my_reg, mz_reg, btn_reg, key_reg;
    logic               status_reg;

    always_comb
    begin
        ch0  = chan_sub({5'd0, frame[1][2:0], frame[0]}, cfg.offset);
        ch1  = chan_sub({5'd0, frame[2][5:0], frame[1][7:3]}, cfg.offset);
        ch2  = chan_sub({5'd0, frame[4][0], frame[3], frame[2][7:6]}, cfg.offset);
        ch3  = chan_sub({5'd0, frame[5][3:0], frame[4][7:1]}, cfg.offset);
        ch4  = chan_sub({frame[17], frame[16]}, cfg.offset);
        sw_l = frame[5][5:4];
        sw_r = frame[5][7:6];
        bad  = over_limit(ch0, cfg.limit) || over_limit(ch1, cfg.limit)
            || over_limit(ch2, cfg.limit) || over_limit(ch3, cfg.limit)
            || sw_l == '0 || sw_r == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (stat.load)
            valid_reg <= 1'b1;
        else if (res.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stat.load)
        begin
            status_reg <= bad;
            if (bad)
            begin
                {ch0_reg, ch1_reg, ch2_reg, ch3_reg, ch4_reg} <= '0;
                {mx_reg, my_reg, mz_reg, btn_reg, key_reg}    <= '0;
                sw_reg <= {cfg.failsafe_sw, cfg.failsafe_sw};
            end
            else
            begin
                ch0_reg <= ch0;
                ch1_reg <= ch1;
                ch2_reg <= ch2;
                ch3_reg <= ch3;
                ch4_reg <= ch4;
                sw_reg  <= {sw_r, sw_l};
                mx_reg  <= {frame[7], frame[6]};
                my_reg  <= {frame[9], frame[8]};
                mz_reg  <= {frame[11], frame[10]};
                btn_reg <= {frame[13], frame[12]};
                key_reg <= {frame[15], frame[14]};
            end
        end
    end

    assign res.valid         = valid_reg;
    assign res.chan0         = ch0_reg;
    assign res.chan1         = ch1_reg;
    assign res.chan2         = ch2_reg;
    assign res.chan3         = ch3_reg;
    assign res.chan4         = ch4_reg;
    assign res.switches      = sw_reg;
    assign res.mouse_x       = mx_reg;
    assign res.mouse_y       = my_reg;
    assign res.mouse_z       = mz_reg;
    assign res.mouse_buttons = btn_reg;
    assign res.key_word      = key_reg;
    assign res.status        = status_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stat.load |-> !(valid_reg && !res.ready))
        else $error("result word overwritten while stalled");
    a_load_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        stat.load |-> stat.complete)
        else $error("decode without a full frame");
    a_failsafe_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && status_reg |-> ch0_reg == '0 && ch4_reg == '0
            && key_reg == '0 && mx_reg == '0)
        else $error("fail-safe word carries data");
`endif

endmodule

// ===== rtl/remote_control_frame_decoder.sv =====
// Remote control frame decoder, 18-byte frames.
// rx: input words, each a received byte (opcode byte) or a line-idle event.
//   Bytes fill the frame store; an idle event ends the frame.
// res: one result word per idle event that closes a frame of exactly 18
//   bytes; other idle events give nothing. Channels are offset-corrected; frames
//   out of range or with a zero switch field give fail-safe values, status set.
// APB port: offset at 0x0, error limit at 0x4, fail-safe switch at 0x8.
// Throughput: one input word per cycle unless an idle event waits on a stalled
//   result. Latency: the result word is valid the cycle after the idle event is
//   taken (one register stage after the frame store).
// Stall: the result register holds until res.ready; meanwhile bytes are
//   still taken, an idle event waits until the result is taken or
//   leaves in the same cycle.
// Reset: byte count cleared, registers at defaults, no result pending.
module remote_control_frame_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcfd_pkg::DATA_W-1:0]   pwdata,
    output logic [rcfd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    rcfd_in_if.sink                       rx,
    rcfd_out_if.source                    res
);
    import rcfd_pkg::*;

    cfg_t        cfg;
    frame_t      frame;
    store_stat_t stat;
    logic        accept;

    assign rx.ready = !res.valid || res.ready || rx.opcode == OP_BYTE;
    assign accept   = rx.valid && rx.ready;

    rcfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcfd_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .opcode  (rx.opcode),
        .rx_byte (rx.rx_byte),
        .frame   (frame),
        .stat    (stat)
    );

    rcfd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame),
        .stat  (stat),
        .cfg   (cfg),
        .res   (res)
    );

endmodule

// ===== tb/sv/rcfd_frame_compare.sv =====
`timescale 1ns / 1ps

module rcfd_frame_compare (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [rcfd_pkg::ADDR_W-1:0] paddr,
    input  logic [rcfd_pkg::DATA_W-1:0] pwdata,
    rcfd_in_if                          rx,
    rcfd_out_if                         res,
    output int                          fail_count,
    output int                          waiting
);
    import rcfd_pkg::*;

    typedef struct packed {
        logic [15:0] chan0;
        logic [15:0] chan1;
        logic [15:0] chan2;
        logic [15:0] chan3;
        logic [15:0] chan4;
        logic [3:0]  switches;
        logic [15:0] mouse_x;
        logic [15:0] mouse_y;
        logic [15:0] mouse_z;
        logic [15:0] mouse_buttons;
        logic [15:0] key_word;
        logic        status;
    } decoded_t;

    cfg_t        cfg;
    frame_t      rx_frame;
    int unsigned byte_cnt;
    decoded_t    decoded_q [$];
    decoded_t    want;
    int          mismatches;

    function automatic decoded_t decode_frame(input frame_t f, input cfg_t c);
        logic [15:0] ch [5];
        logic [1:0]  sw_l;
        logic [1:0]  sw_r;
        logic [16:0] mag;
        logic        bad;
        decoded_t    d;
        ch[0] = {5'b0, f[1][2:0], f[0]};
        ch[1] = {5'b0, f[2][5:0], f[1][7:3]};
        ch[2] = {5'b0, f[4][0], f[3], f[2][7:6]};
        ch[3] = {5'b0, f[5][3:0], f[4][7:1]};
        ch[4] = {f[17], f[16]};
        sw_l  = f[5][5:4];
        sw_r  = f[5][7:6];
        for (int i = 0; i < 5; i++)
            ch[i] = ch[i] - {5'b0, c.offset};
        bad = (sw_l == 2'd0) || (sw_r == 2'd0);
        for (int i = 0; i < 4; i++)
        begin
            mag = ch[i][15] ? 17'h10000 - {1'b0, ch[i]} : {1'b0, ch[i]};
            if (mag > {6'b0, c.limit})
                bad = 1'b1;
        end
        d = '0;
        if (bad)
        begin
            d.switches = {c.failsafe_sw, c.failsafe_sw};
            d.status   = 1'b1;
        end
        else
        begin
            d.chan0         = ch[0];
            d.chan1         = ch[1];
            d.chan2         = ch[2];
            d.chan3         = ch[3];
            d.chan4         = ch[4];
            d.switches      = {sw_r, sw_l};
            d.mouse_x       = {f[7], f[6]};
            d.mouse_y       = {f[9], f[8]};
            d.mouse_z       = {f[11], f[10]};
            d.mouse_buttons = {f[13], f[12]};
            d.key_word      = {f[15], f[14]};
        end
        return d;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.offset      = OFFSET_RST;
            cfg.limit       = LIMIT_RST;
            cfg.failsafe_sw = FAILSAFE_RST;
            byte_cnt        = 0;
            decoded_q.delete();
            mismatches      = 0;
            fail_count     <= 0;
            waiting        <= 0;
        end
        else
        begin
            // results first: a result word never leaves in the cycle its idle is taken
            if (res.valid && res.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("chan0", want.chan0, res.chan0);
                    check_field("chan1", want.chan1, res.chan1);
                    check_field("chan2", want.chan2, res.chan2);
                    check_field("chan3", want.chan3, res.chan3);
                    check_field("chan4", want.chan4, res.chan4);
                    check_field("switches", {12'b0, want.switches}, {12'b0, res.switches});
                    check_field("mouse_x", want.mouse_x, res.mouse_x);
                    check_field("mouse_y", want.mouse_y, res.mouse_y);
                    check_field("mouse_z", want.mouse_z, res.mouse_z);
                    check_field("mouse_buttons", want.mouse_buttons, res.mouse_buttons);
                    check_field("key_word", want.key_word, res.key_word);
                    check_field("status", {15'b0, want.status}, {15'b0, res.status});
                end
            end

            if (rx.valid && rx.ready)
            begin
                if (rx.opcode == OP_BYTE)
                begin
                    if (byte_cnt < FRAME_BYTES)
                        rx_frame[byte_cnt] = rx.rx_byte;
                    if (byte_cnt <= FRAME_BYTES)
                        byte_cnt++;
                end
                else
                begin
                    if (byte_cnt == FRAME_BYTES)
                        decoded_q.push_back(decode_frame(rx_frame, cfg));
                    byte_cnt = 0;
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_OFFSET:   cfg.offset      = pwdata[STICK_W-1:0];
                    REG_LIMIT:    cfg.limit       = pwdata[STICK_W-1:0];
                    REG_FAILSAFE: cfg.failsafe_sw = pwdata[SW_W-1:0];
                    default:      ;
                endcase
            end

            fail_count <= mismatches;
            waiting    <= decoded_q.size();
        end
    end

endmodule

// ===== tb/sv/remote_control_frame_decoder_tb.sv =====
`timescale 1ns / 1ps

module remote_control_frame_decoder_tb;
    import rcfd_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int         PHASES   = 6;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                waiting;

    int                gap_pct;
    int                stall_pct;
    int                sent;
    logic [10:0]       cur_offset;
    logic [10:0]       cur_limit;

    rcfd_in_if  rx_if ();
    rcfd_out_if res_if ();

    remote_control_frame_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (rx_if),
        .res     (res_if)
    );

    rcfd_frame_compare i_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .rx         (rx_if),
        .res        (res_if),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        res_if.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic put_word(input opcode_t op, input logic [7:0] data);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.opcode  <= op;
        rx_if.rx_byte <= data;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sent++;
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        repeat (3) @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [10:0] offset, input logic [10:0] limit,
                              input logic [1:0] fs);
        logic [31:0] v;
        drain();
        v = $urandom;
        v[10:0] = offset;
        reg_write(REG_OFFSET, v);
        v = $urandom;
        v[10:0] = limit;
        reg_write(REG_LIMIT, v);
        v = $urandom;
        v[1:0] = fs;
        reg_write(REG_FAILSAFE, v);
        reg_write(REG_NONE, $urandom);
        cur_offset = offset;
        cur_limit  = limit;
    endtask

    task automatic send_bytes(input int n);
        for (int i = 0; i < n; i++)
            put_word(OP_BYTE, 8'($urandom));
        put_word(OP_IDLE, 8'($urandom));
    endtask

    // sticks land around the offset so most frames pass the range check
    task automatic send_frame(input bit sticks_ok, input bit switches_ok);
        logic [10:0] stick [4];
        logic [1:0]  sw_l;
        logic [1:0]  sw_r;
        logic [7:0]  fb [FRAME_BYTES];
        int          span;
        int          bad_ch;
        span   = int'(cur_limit);
        bad_ch = -1;
        if (!sticks_ok)
            bad_ch = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(0, 3))
                0:       stick[i] = 11'(int'(cur_offset) - span);
                1:       stick[i] = 11'(int'(cur_offset) + span);
                default: stick[i] = 11'(int'(cur_offset) + int'($urandom_range(0, 2 * span))
                                        - span);
            endcase
            if (i == bad_ch)
            begin
                case ($urandom_range(0, 2))
                    0:       stick[i] = 11'(int'(cur_offset) + span + 1);
                    1:       stick[i] = 11'(int'(cur_offset) - span - 1);
                    default: stick[i] = 11'($urandom);
                endcase
            end
        end
        sw_l = 2'($urandom_range(1, 3));
        sw_r = 2'($urandom_range(1, 3));
        if (!switches_ok)
        begin
            case ($urandom_range(0, 2))
                0:       sw_l = 2'd0;
                1:       sw_r = 2'd0;
                default:
                begin
                    sw_l = 2'd0;
                    sw_r = 2'd0;
                end
            endcase
        end
        fb[0] = stick[0][7:0];
        fb[1] = {stick[1][4:0], stick[0][10:8]};
        fb[2] = {stick[2][1:0], stick[1][10:5]};
        fb[3] = stick[2][9:2];
        fb[4] = {stick[3][6:0], stick[2][10]};
        fb[5] = {sw_r, sw_l, stick[3][10:7]};
        for (int i = 6; i < FRAME_BYTES; i++)
            fb[i] = 8'($urandom);
        for (int i = 0; i < FRAME_BYTES; i++)
            put_word(OP_BYTE, fb[i]);
        put_word(OP_IDLE, 8'($urandom));
    endtask

    initial
    begin
        int gap_tbl [PHASES];
        int stall_tbl [PHASES];
        int target;
        int pick;
        gap_tbl    = '{0, 20, 10, 30, 15, 0};
        stall_tbl  = '{15, 0, 25, 10, 30, 0};
        gap_pct    = 0;
        stall_pct  = 0;
        sent       = 0;
        cur_offset = OFFSET_RST;
        cur_limit  = LIMIT_RST;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.opcode  <= OP_BYTE;
        rx_if.rx_byte <= 8'h00;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // lone idle, full frame of ones, short frame of zeros
        put_word(OP_IDLE, 8'h00);
        for (int i = 0; i < FRAME_BYTES; i++)
            put_word(OP_BYTE, 8'hFF);
        put_word(OP_IDLE, 8'hFF);
        for (int i = 0; i < 3; i++)
            put_word(OP_BYTE, 8'h00);
        put_word(OP_IDLE, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:       set_config(11'd0, 11'd2047, 2'd0);
                2:       set_config(11'd2047, 11'd0, 2'd3);
                3:       set_config(11'($urandom), 11'($urandom_range(200, 1000)), 2'd1);
                4, 5:    set_config(11'($urandom), 11'($urandom_range(100, 1200)),
                                    2'($urandom_range(0, 3)));
                default: ;
            endcase
            gap_pct   = gap_tbl[p];
            stall_pct = stall_tbl[p];
            target    = sent + 315;
            while (sent < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    send_frame(1'b1, 1'b1);
                else if (pick < 70)
                    send_frame(1'b0, 1'b1);
                else if (pick < 75)
                    send_frame(1'b1, 1'b0);
                else if (pick < 85)
                    send_bytes($urandom_range(0, FRAME_BYTES - 1));
                else if (pick < 93)
                    send_bytes($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 12));
                else if (pick < 98)
                begin
                    repeat ($urandom_range(1, 6))
                        put_word(opcode_t'($urandom_range(0, 1)), 8'($urandom));
                end
                else if (p != PHASES - 1)
                    drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rcfd_pkg.sv
rtl/rcfd_in_if.sv
rtl/rcfd_out_if.sv
rtl/rcfd_regs.sv
rtl/rcfd_store.sv
rtl/rcfd_decode.sv
rtl/remote_control_frame_decoder.sv
tb/sv/rcfd_frame_compare.sv
tb/sv/remote_control_frame_decoder_tb.sv
